>>> hdl/cdsr_pkg.sv
// Shared types, constants and helpers for the character display refresh block.
`timescale 1ns / 1ps

package cdsr_pkg;

  localparam int COL_W       = 5;   // scan column width
  localparam int ROW_W       = 2;   // scan row width
  localparam int ADDR_W      = 7;   // cell address width, up to 4 x 20 cells
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] ADDR_SET   = 8'h80;
  localparam logic [7:0] SPACE_CODE = 8'h20;
  localparam logic [7:0] ROW0_BASE  = 8'h00;
  localparam logic [7:0] ROW1_BASE  = 8'h40;
  localparam logic [7:0] ROW2_BASE  = 8'h14;
  localparam logic [7:0] ROW3_BASE  = 8'h54;

  typedef enum logic [1:0] {
    KIND_LOCATE = 2'd0,
    KIND_CHAR   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_CLEAR = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] col;
    logic [7:0] row;
    logic [7:0] char_code;
  } cdsr_cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_data;
    logic       last;
  } cdsr_result_t;

  // One unit of work for the back end.
  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        ch;
  } cdsr_job_t;

  // Queue status seen by the back end.
  typedef struct packed {
    logic      valid;
    cdsr_job_t job;
  } cdsr_head_t;

  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] y);
    logic [7:0] b;
    unique case (y)
      2'd0:    b = ROW0_BASE;
      2'd1:    b = ROW1_BASE;
      2'd2:    b = ROW2_BASE;
      default: b = ROW3_BASE;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] addr_cmd(input logic [COL_W-1:0] x,
                                          input logic [ROW_W-1:0] y);
    return ADDR_SET | (8'(x) + row_base(y));
  endfunction

endpackage

>>> hdl/cdsr_front.sv
// Front end: takes requests, keeps the write cursor and turns requests into back-end jobs.
`timescale 1ns / 1ps

module cdsr_front
  import cdsr_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 20
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  cdsr_cmd_t cmd,
  input  logic      full,
  output logic      busy,
  output logic      push,
  output cdsr_job_t job
);

  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic       take;
  logic       in_range;
  logic       col_wrap;
  logic       row_wrap;

  assign busy     = full;
  assign take     = start && !full;
  assign in_range = (int'(cursor_col) < COLS) && (int'(cursor_row) < ROWS);
  assign col_wrap = (int'(cursor_col) + 1) >= COLS;
  assign row_wrap = (int'(cursor_row) + 1) >= ROWS;

  always_comb begin
    push     = 1'b0;
    job.op   = OP_TICK;
    job.addr = ADDR_W'(cursor_row[ROW_W-1:0]) * ADDR_W'(COLS)
             + ADDR_W'(cursor_col[COL_W-1:0]);
    job.ch   = cmd.char_code;
    if (take) begin
      unique case (kind_t'(cmd.kind))
        KIND_LOCATE: push = 1'b0;
        KIND_CHAR: begin
          push   = in_range;
          job.op = OP_WRITE;
        end
        KIND_CLEAR: begin
          push   = 1'b1;
          job.op = OP_CLEAR;
        end
        default: begin
          push   = 1'b1;
          job.op = OP_TICK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= '0;
      cursor_row <= '0;
    end else if (take) begin
      unique case (kind_t'(cmd.kind))
        KIND_LOCATE: begin
          cursor_col <= cmd.col;
          cursor_row <= cmd.row;
        end
        KIND_CHAR: begin
          // advance only when the character was stored
          if (in_range) begin
            if (col_wrap) begin
              cursor_col <= '0;
              cursor_row <= row_wrap ? 8'd0 : cursor_row + 8'd1;
            end else begin
              cursor_col <= cursor_col + 8'd1;
            end
          end
        end
        KIND_CLEAR: begin
          cursor_col <= '0;
          cursor_row <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hdl/cdsr_queue.sv
// Short job queue between the front end and the back end.
`timescale 1ns / 1ps

module cdsr_queue
  import cdsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  cdsr_job_t  job_in,
  input  logic       pop,
  output cdsr_head_t head,
  output logic       full
);

  cdsr_job_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign full       = (int'(count) == QUEUE_DEPTH);
  assign head.valid = (count != '0);
  assign head.job   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + (QPTR_W+1)'(1);
        2'b01:   count <= count - (QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> hdl/cdsr_back.sv
// Back end: frame buffer and shadow memories, scan position and result sequencing.
`timescale 1ns / 1ps

module cdsr_back
  import cdsr_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  cdsr_head_t   head,
  output logic         pop,
  output cdsr_result_t result,
  output logic         strobe
);

  localparam int CELLS = ROWS * COLS;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EVAL = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t            state;
  logic [7:0]        text_mem  [CELLS];
  logic [7:0]        shown_mem [CELLS];
  logic [CELLS-1:0]  text_valid;
  logic [CELLS-1:0]  shown_valid;
  logic              text_spaced;

  logic [COL_W-1:0]  scan_col;
  logic [ROW_W-1:0]  scan_row;
  logic              run_open;

  logic [COL_W-1:0]  rd_x;
  logic [ROW_W-1:0]  rd_y;
  logic [ADDR_W-1:0] rd_idx;

  logic [ADDR_W-1:0] tick_idx;
  logic [COL_W-1:0]  tick_x;
  logic [ROW_W-1:0]  tick_y;
  logic [7:0]        text_rd;
  logic [7:0]        shown_rd;
  logic              text_vq;
  logic              shown_vq;
  logic              spaced_q;

  logic [7:0]        text_val;
  logic [7:0]        shown_val;
  logic              changed;
  cdsr_result_t      slot_n [3];
  logic [1:0]        cnt_n;
  cdsr_result_t      slot [3];
  logic [1:0]        slot_cnt;
  logic [1:0]        slot_idx;
  logic [COL_W-1:0]  x_next;
  logic [ROW_W-1:0]  y_next;

  assign pop = (state == ST_IDLE) && head.valid;

  // Out-of-range scan position restarts at the first cell.
  always_comb begin
    if (int'(scan_col) >= COLS || int'(scan_row) >= ROWS) begin
      rd_x = '0;
      rd_y = '0;
    end else begin
      rd_x = scan_col;
      rd_y = scan_row;
    end
    rd_idx = ADDR_W'(rd_y) * ADDR_W'(COLS) + ADDR_W'(rd_x);
  end

  assign text_val  = text_vq ? text_rd : (spaced_q ? SPACE_CODE : 8'h00);
  assign shown_val = shown_vq ? shown_rd : 8'h00;
  assign changed   = (text_val != shown_val);

  always_comb begin
    logic [1:0] k;
    k = 2'd0;
    for (int i = 0; i < 3; i++) begin
      slot_n[i] = '0;
    end
    if (tick_x == '0) begin
      slot_n[k] = '{out_byte: addr_cmd('0, tick_y), is_data: 1'b0, last: 1'b0};
      k = k + 2'd1;
    end
    if (changed && !run_open) begin
      slot_n[k] = '{out_byte: addr_cmd(tick_x, tick_y), is_data: 1'b0, last: 1'b0};
      k = k + 2'd1;
    end
    if (changed) begin
      slot_n[k] = '{out_byte: text_val, is_data: 1'b1, last: 1'b0};
      k = k + 2'd1;
    end
    for (int i = 0; i < 3; i++) begin
      slot_n[i].last = (k != 2'd0) && (2'(i) == k - 2'd1);
    end
    cnt_n = k;
  end

  always_comb begin
    if ((int'(tick_x) + 1) >= COLS) begin
      x_next = '0;
      y_next = ((int'(tick_y) + 1) >= ROWS) ? '0 : tick_y + ROW_W'(1);
    end else begin
      x_next = tick_x + COL_W'(1);
      y_next = tick_y;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.job.op == OP_WRITE) begin
      text_mem[head.job.addr] <= head.job.ch;
    end
    if (pop && head.job.op == OP_TICK) begin
      text_rd <= text_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EVAL && changed) begin
      shown_mem[tick_idx] <= text_val;
    end
    if (pop && head.job.op == OP_TICK) begin
      shown_rd <= shown_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      text_valid  <= '0;
      shown_valid <= '0;
      text_spaced <= 1'b0;
      scan_col    <= '0;
      scan_row    <= '0;
      run_open    <= 1'b0;
      strobe      <= 1'b0;
      slot_cnt    <= '0;
      slot_idx    <= '0;
    end else begin
      // Strobe is the emit state delayed by a register, in step with the registered result.
      strobe <= (state == ST_EMIT);
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            unique case (head.job.op)
              OP_WRITE: text_valid[head.job.addr] <= 1'b1;
              OP_CLEAR: begin
                text_valid  <= '0;
                text_spaced <= 1'b1;
              end
              OP_TICK: begin
                text_vq  <= text_valid[rd_idx];
                shown_vq <= shown_valid[rd_idx];
                spaced_q <= text_spaced;
                tick_idx <= rd_idx;
                tick_x   <= rd_x;
                tick_y   <= rd_y;
                state    <= ST_EVAL;
              end
              default: ;
            endcase
          end
        end
        ST_EVAL: begin
          if (changed) begin
            shown_valid[tick_idx] <= 1'b1;
          end
          run_open <= changed;
          scan_col <= x_next;
          scan_row <= y_next;
          for (int i = 0; i < 3; i++) begin
            slot[i] <= slot_n[i];
          end
          slot_cnt <= cnt_n;
          slot_idx <= '0;
          state    <= (cnt_n == 2'd0) ? ST_IDLE : ST_EMIT;
        end
        ST_EMIT: begin
          result   <= slot[slot_idx];
          slot_idx <= slot_idx + 2'd1;
          if (slot_idx == slot_cnt - 2'd1) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/char_display_shadow_refresh.sv
// Top level of the character display frame buffer with shadow-diff refresh.
`timescale 1ns / 1ps
// Path: a taken tick request is queued, popped in the idle state, evaluated, then emitted;
//   the results of one tick follow back to back.
// Occupancy: the back end handles a write or clear job in the idle state alone and takes a
//   tick through idle and evaluate, then emits its n results (0 to 3) before the next job.
// Requests are taken while the 4-entry job queue has room; results cannot be stalled.
// Reset: synchronous; both stores read as zero at once through per-cell valid bits, no sweep.

module char_display_shadow_refresh
  import cdsr_pkg::*;
#(
  parameter int ROWS = 4,
  parameter int COLS = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  cdsr_cmd_t    cmd,
  output logic         busy,
  output cdsr_result_t result,
  output logic         strobe
);

  // Front to queue
  logic       push;
  cdsr_job_t  job;
  logic       full;

  // Queue to back
  cdsr_head_t head;
  logic       pop;

  // Front end: hold the cursor, drop characters outside the panel, queue real work.
  cdsr_front #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .full  (full),
    .busy  (busy),
    .push  (push),
    .job   (job)
  );

  // Queue: keep request order so buffer writes and scans stay in sequence.
  cdsr_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .full   (full)
  );

  // Back end: edit the buffer, scan one cell per tick and emit the byte stream.
  cdsr_back #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result),
    .strobe (strobe)
  );

  // A data byte always closes its tick.
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.is_data |-> result.last)
    else $error("data byte not marked last");

  // Results of one tick leave back to back.
  assert property (@(posedge clk) disable iff (rst)
    strobe && !result.last |=> strobe)
    else $error("gap inside a tick's results");

  // A new tick needs at least the pop and evaluate states before its results.
  assert property (@(posedge clk) disable iff (rst)
    strobe && result.last |=> !strobe)
    else $error("results of two ticks run together");

  // Nothing is popped while the queue is empty.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from empty queue");

endmodule

>>> tb/char_display_shadow_refresh_test.sv
// Self-checking testbench for the character display shadow-diff refresh block.
`timescale 1ns / 1ps

module char_display_shadow_refresh_test;
  import cdsr_pkg::*;

  localparam int ROWS = 4;
  localparam int COLS = 20;
  localparam int CELLS = ROWS * COLS;
  localparam int RANDOM_ITEMS = 250;
  localparam int SETTLE_CYCLES = 16;     // comfortably past the result latency

  // Tracks the block's frame buffer, shadow and scan position, and holds the
  // panel bytes that each accepted refresh tick must produce, oldest first.
  class refresh_stream_check;
    logic [7:0]   text_cells [CELLS];
    logic [7:0]   shown_cells [CELLS];
    logic [7:0]   cur_col;
    logic [7:0]   cur_row;
    logic [4:0]   scan_col;
    logic [1:0]   scan_row;
    logic         run_open;
    cdsr_result_t panel_bytes [$];
    int           errors;

    function new();
      foreach (text_cells[i]) begin
        text_cells[i] = 8'h00;
        shown_cells[i] = 8'h00;
      end
      cur_col = 8'h00;
      cur_row = 8'h00;
      scan_col = '0;
      scan_row = '0;
      run_open = 1'b0;
      errors = 0;
    endfunction

    function int outstanding();
      return panel_bytes.size();
    endfunction

    // Apply one accepted request and queue whatever bytes it must produce.
    function void note_request(cdsr_cmd_t c);
      logic [4:0]   x;
      logic [1:0]   y;
      logic [7:0]   base;
      int           idx;
      cdsr_result_t tick_bytes [$];
      case (kind_t'(c.kind))
        KIND_LOCATE: begin
          cur_col = c.col;
          cur_row = c.row;
        end
        KIND_CHAR: begin
          if (cur_col < COLS && cur_row < ROWS) begin
            text_cells[cur_row * COLS + cur_col] = c.char_code;
            if (cur_col == COLS - 1) begin
              cur_col = 8'h00;
              cur_row = (cur_row == ROWS - 1) ? 8'h00 : cur_row + 8'd1;
            end else begin
              cur_col = cur_col + 8'd1;
            end
          end
        end
        KIND_CLEAR: begin
          foreach (text_cells[i]) text_cells[i] = SPACE_CODE;
          cur_col = 8'h00;
          cur_row = 8'h00;
        end
        default: begin
          x = scan_col;
          y = scan_row;
          if (x >= COLS || y >= ROWS) begin
            x = '0;
            y = '0;
          end
          case (y)
            2'd0:    base = ROW0_BASE;
            2'd1:    base = ROW1_BASE;
            2'd2:    base = ROW2_BASE;
            default: base = ROW3_BASE;
          endcase
          idx = y * COLS + x;
          if (x == 0)
            tick_bytes.push_back(cdsr_result_t'{out_byte: ADDR_SET | base,
                                                is_data: 1'b0, last: 1'b0});
          if (text_cells[idx] != shown_cells[idx]) begin
            if (!run_open)
              tick_bytes.push_back(cdsr_result_t'{out_byte: ADDR_SET | (8'(x) + base),
                                                  is_data: 1'b0, last: 1'b0});
            tick_bytes.push_back(cdsr_result_t'{out_byte: text_cells[idx],
                                                is_data: 1'b1, last: 1'b0});
            shown_cells[idx] = text_cells[idx];
            run_open = 1'b1;
          end else begin
            run_open = 1'b0;
          end
          if (tick_bytes.size() > 0) tick_bytes[tick_bytes.size() - 1].last = 1'b1;
          foreach (tick_bytes[i]) panel_bytes.push_back(tick_bytes[i]);
          if (x == COLS - 1) begin
            x = '0;
            y = (y == ROWS - 1) ? 2'd0 : y + 2'd1;
          end else begin
            x = x + 5'd1;
          end
          scan_col = x;
          scan_row = y;
        end
      endcase
    endfunction

    function void check_result(cdsr_result_t got);
      cdsr_result_t want;
      if (panel_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected byte 0x%02h is_data=%b last=%b", $time,
                 got.out_byte, got.is_data, got.last);
        return;
      end
      want = panel_bytes.pop_front();
      if (got.out_byte !== want.out_byte || got.is_data !== want.is_data ||
          got.last !== want.last) begin
        errors++;
        $display("%0t: mismatch expected 0x%02h/%b/%b actual 0x%02h/%b/%b", $time,
                 want.out_byte, want.is_data, want.last,
                 got.out_byte, got.is_data, got.last);
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         start = 1'b0;
  cdsr_cmd_t    cmd = '0;
  logic         busy;
  cdsr_result_t result;
  logic         strobe;

  refresh_stream_check board = new();
  int           burst_left = 0;
  int           sent = 0;

  char_display_shadow_refresh #(.ROWS(ROWS), .COLS(COLS)) uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .result (result),
    .strobe (strobe)
  );

  always #10 clk = ~clk;

  // Take each strobed byte at the edge that closes its cycle; values read here are
  // the ones from before the edge, so the block's own updates cannot race us.
  always @(posedge clk) begin
    if (!rst && strobe === 1'b1) board.check_result(result);
  end

  // Hard stop in case the block hangs or drops bytes.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic cdsr_cmd_t make_req(kind_t k, logic [7:0] c, logic [7:0] r,
                                         logic [7:0] ch);
    return cdsr_cmd_t'{kind: k, col: c, row: r, char_code: ch};
  endfunction

  // Present one request, hold it until the block takes it, then idle between bursts.
  task automatic send_request(input cdsr_cmd_t c);
    int gap;
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy !== 1'b0);
    board.note_request(c);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // Mostly short bursts with short gaps; now and then a long unbroken run.
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(0, 12);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold off the sender until every queued byte has come out.
  task automatic drain_panel_bytes();
    start <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  task automatic send_tick();
    send_request(make_req(KIND_TICK, 8'($urandom), 8'($urandom), 8'($urandom)));
  endtask

  // Random character: mostly anything, sometimes a space or zero so cells stay unchanged.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 7))
      0:       return SPACE_CODE;
      1:       return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int pick;
    int n;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part.
    send_tick();                                                  // row 0 start, nothing changed
    send_request(make_req(KIND_LOCATE, 8'hFF, 8'hFF, 8'h00));      // both out of range
    send_request(make_req(KIND_CHAR, 8'h00, 8'h00, 8'hFF));        // dropped
    send_request(make_req(KIND_LOCATE, 8'd20, 8'd0, 8'hFF));       // column just past the edge
    send_request(make_req(KIND_CHAR, 8'hFF, 8'hFF, 8'h11));        // dropped
    send_request(make_req(KIND_LOCATE, 8'd0, 8'd4, 8'h00));        // row just past the edge
    send_request(make_req(KIND_CHAR, 8'h00, 8'h00, 8'h22));        // dropped
    send_request(make_req(KIND_LOCATE, 8'd19, 8'd3, 8'h00));       // last cell
    send_request(make_req(KIND_CHAR, 8'h00, 8'h00, 8'hFF));        // stored, cursor wraps home
    send_request(make_req(KIND_CHAR, 8'hFF, 8'hFF, 8'h00));        // same as shown: no change
    send_request(make_req(KIND_CHAR, 8'h00, 8'h00, 8'hA5));        // cell (1,0) changes
    send_tick();                                                  // changed (1,0), opens a run
    send_tick();                                                  // unchanged mid-row: silent
    send_tick();                                                  // still unchanged: silent
    send_request(make_req(KIND_CLEAR, 8'hAA, 8'h55, 8'hC3));
    send_tick();                                                  // space versus zero: new run
    send_tick();                                                  // run continues, data only
    send_request(make_req(KIND_CHAR, 8'h55, 8'hAA, 8'h5A));        // after clear lands at home
    send_request(make_req(KIND_LOCATE, 8'd5, 8'd1, 8'h3C));
    send_request(make_req(KIND_CHAR, 8'd0, 8'd0, SPACE_CODE));
    drain_panel_bytes();

    // Random part: mostly edit-then-refresh sequences, with some noise.
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_request(make_req(KIND_LOCATE, 8'($urandom_range(0, COLS - 1)),
                              8'($urandom_range(0, ROWS - 1)), 8'($urandom)));
        n = $urandom_range(1, 8);
        repeat (n) send_request(make_req(KIND_CHAR, 8'($urandom), 8'($urandom), pick_char()));
      end else if (pick < 75) begin
        n = $urandom_range(5, 30);
        repeat (n) send_tick();
      end else if (pick < 80) begin
        send_request(make_req(KIND_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom)));
      end else if (pick < 88) begin
        // Broken sequence: stray locate, characters mostly dropped.
        send_request(make_req(KIND_LOCATE, 8'($urandom), 8'($urandom), 8'($urandom)));
        n = $urandom_range(1, 3);
        repeat (n) send_request(make_req(KIND_CHAR, 8'($urandom), 8'($urandom), pick_char()));
      end else if (pick < 96) begin
        send_request(make_req(kind_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                              8'($urandom)));
      end else begin
        drain_panel_bytes();
      end
    end

    // Drop start, let everything drain, then allow for any late stray bytes.
    drain_panel_bytes();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
